/* sv/brpt_pkg.sv */
// Shared types and constants for the binary relation pair table.
`default_nettype none

package brpt_pkg;

  // Default sizes
  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_KEY_WIDTH    = 32;

  // Fixed field widths of the request and result
  localparam int OPCODE_W      = 2;
  localparam int KEY_FIELD_W   = 32;
  localparam int COUNT_FIELD_W = 7;

  // Opcodes; the unused code behaves as a query
  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [KEY_FIELD_W-1:0] first_key;
    logic [KEY_FIELD_W-1:0] second_key;
  } in_item_t;

  typedef struct packed {
    logic                     related;
    logic                     pair_present;
    logic [COUNT_FIELD_W-1:0] element_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MODIFY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the request
    logic lookup;  // match keys, enter new keys, read the row
    logic finish;  // write the row back, load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

`default_nettype wire

/* sv/brpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/brpt_ctrl.sv */
// Request sequencer: idle, key lookup, row modify and result hand-off.
`default_nettype none

module brpt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire brpt_pkg::status_t sts,
  output      brpt_pkg::cmd_t    cmd
);

  brpt_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brpt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = brpt_pkg::ST_LOOKUP;
      end
      brpt_pkg::ST_LOOKUP: begin
        state_nxt = brpt_pkg::ST_MODIFY;
      end
      brpt_pkg::ST_MODIFY: begin
        // hold until the result register is free
        if (sts.out_free) state_nxt = brpt_pkg::ST_IDLE;
      end
      default: state_nxt = brpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      brpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      brpt_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      brpt_pkg::ST_MODIFY: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/brpt_dp.sv */
// Datapath: key table with parallel match, row memory and result register.
`default_nettype none

module brpt_dp #(
  parameter int MAX_ELEMENTS = brpt_pkg::DEF_MAX_ELEMENTS,
  parameter int KEY_WIDTH    = brpt_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire brpt_pkg::in_item_t  in_data,
  input  wire brpt_pkg::cmd_t      cmd,
  output      brpt_pkg::status_t   sts,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      brpt_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  // only key bits below KEY_WIDTH take part
  localparam int SK_W  = (KEY_WIDTH < brpt_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                              : brpt_pkg::KEY_FIELD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  // Request registers
  logic [brpt_pkg::OPCODE_W-1:0] op_r;
  logic [SK_W-1:0]               fk_r, sk_r;

  // Key table and fill count
  logic [SK_W-1:0]  tbl_r [MAX_ELEMENTS];
  logic [CNT_W-1:0] count_r;

  // Lookup results
  logic [IDX_W-1:0] fidx_r, sidx_r;
  logic             pres_r;

  // Row valid bits; a row never written reads as zero
  logic [MAX_ELEMENTS-1:0] row_vld_r;

  // Result register
  logic                out_valid_r;
  brpt_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.opcode;
      fk_r <= SK_W'(in_data.first_key);
      sk_r <= SK_W'(in_data.second_key);
    end
  end

  // Parallel key match against the filled entries
  logic [MAX_ELEMENTS-1:0] fmatch, smatch;
  logic [IDX_W-1:0]        fidx_hit, sidx_hit;
  logic                    fhit, shit;

  always_comb begin
    fidx_hit = '0;
    sidx_hit = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      fmatch[i] = (CNT_W'(i) < count_r) && (tbl_r[i] == fk_r);
      smatch[i] = (CNT_W'(i) < count_r) && (tbl_r[i] == sk_r);
      // keys in the table are distinct, so at most one match each
      if (fmatch[i]) fidx_hit = fidx_hit | IDX_W'(i);
      if (smatch[i]) sidx_hit = sidx_hit | IDX_W'(i);
    end
    fhit = |fmatch;
    shit = |smatch;
  end

  // Enter missing keys, first key then second
  logic             modify;
  logic             fenter, senter, fpres, spres;
  logic [CNT_W-1:0] cnt1, cnt2;
  logic [IDX_W-1:0] fidx, sidx;

  always_comb begin
    modify = (op_r == brpt_pkg::OP_ADD) || (op_r == brpt_pkg::OP_DELETE);
    fenter = modify && !fhit && (count_r < MAX_CNT);
    fidx   = fenter ? count_r[IDX_W-1:0] : fidx_hit;
    fpres  = fhit || fenter;
    cnt1   = count_r + CNT_W'(fenter);
    if (sk_r == fk_r) begin
      senter = 1'b0;
      sidx   = fidx;
      spres  = fpres;
    end else begin
      senter = modify && !shit && (cnt1 < MAX_CNT);
      sidx   = senter ? cnt1[IDX_W-1:0] : sidx_hit;
      spres  = shit || senter;
    end
    cnt2 = cnt1 + CNT_W'(senter);
  end

  // Key table writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (cmd.lookup && fenter && (count_r[IDX_W-1:0] == IDX_W'(i))) begin
        tbl_r[i] <= fk_r;
      end else if (cmd.lookup && senter && (cnt1[IDX_W-1:0] == IDX_W'(i))) begin
        tbl_r[i] <= sk_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.lookup) begin
      count_r <= cnt2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      fidx_r <= fidx;
      sidx_r <= sidx;
      pres_r <= fpres && spres;
    end
  end

  // Row memory: read in lookup, write back in finish
  logic [MAX_ELEMENTS-1:0] row_rd, row_cur, row_new;
  logic                    row_we, rel;

  brpt_ram #(
    .WIDTH (MAX_ELEMENTS),
    .DEPTH (MAX_ELEMENTS)
  ) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (fidx_r),
    .wdata (row_new),
    .re    (cmd.lookup),
    .raddr (fidx),
    .rdata (row_rd)
  );

  // Row modify
  always_comb begin
    row_cur = row_vld_r[fidx_r] ? row_rd : '0;
    row_new = row_cur;
    row_we  = 1'b0;
    if (pres_r && modify) begin
      row_new[sidx_r] = (op_r == brpt_pkg::OP_ADD);
      row_we          = cmd.finish;
    end
    rel = pres_r && row_new[sidx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (row_we) begin
      row_vld_r[fidx_r] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.related       <= rel;
      out_data_r.pair_present  <= pres_r;
      out_data_r.element_count <= brpt_pkg::COUNT_FIELD_W'(count_r);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

/* sv/binary_relation_pair_table_core.sv */
// Top level of the binary relation pair table: controller plus datapath.
//
//  Channel  Ports                          Direction  Contents
//  request  in_valid/in_ready/in_data      in         opcode, first_key, second_key
//  result   out_valid/out_ready/out_data   out        related, pair_present, element_count
//
//  A request passes through accept, key match with table update and row
//  read, then row write-back and result load; this order is set by the row
//  memory's registered read followed by its single write port.
//  Reset (rst_n low, synchronous) empties the key table and marks all rows
//  as zero through per-row valid bits; no clearing pass is needed.
//  A result waiting on out_ready holds the block in its last step; the next
//  request is taken once that result has moved into the output register.
`default_nettype none

module binary_relation_pair_table_core #(
  parameter int MAX_ELEMENTS = brpt_pkg::DEF_MAX_ELEMENTS,
  parameter int KEY_WIDTH    = brpt_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire brpt_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      brpt_pkg::out_item_t out_data
);

  brpt_pkg::cmd_t    cmd;
  brpt_pkg::status_t sts;

  brpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brpt_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .KEY_WIDTH    (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted request goes to lookup next cycle
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.lookup)
    else $error("accepted request did not start lookup");

  // No new request while one is in lookup
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> !in_ready)
    else $error("request port open during lookup");

  // A new result appears only after a finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // Finish never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("finish while result register busy");

endmodule

`default_nettype wire

/* sim/relation_table_monitor.sv */
// Watches both channels of the pair table, predicts each result and compares it.
`timescale 1ns / 1ps

module relation_table_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  brpt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  brpt_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int TABLE_SIZE = brpt_pkg::DEF_MAX_ELEMENTS;
  localparam int KEY_BITS   = brpt_pkg::DEF_KEY_WIDTH;
  localparam int KEY_W      = brpt_pkg::KEY_FIELD_W;

  // Predicted state of the block
  logic [KEY_W-1:0]    known_keys [TABLE_SIZE];
  int                  key_total;
  bit [TABLE_SIZE-1:0] relation   [TABLE_SIZE];

  brpt_pkg::out_item_t pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    key_total   = 0;
  end

  // Index of a held key, -1 when absent
  function automatic int locate_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < key_total; i++) begin
      if (known_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void admit_key(input logic [KEY_W-1:0] key);
    if (locate_key(key) < 0 && key_total < TABLE_SIZE) begin
      known_keys[key_total] = key;
      key_total++;
    end
  endfunction

  // Applies one request to the predicted table and returns its result
  function automatic brpt_pkg::out_item_t apply_request(input brpt_pkg::in_item_t req);
    logic [KEY_W-1:0]    key_mask;
    logic [KEY_W-1:0]    first;
    logic [KEY_W-1:0]    second;
    int                  row;
    int                  col;
    brpt_pkg::out_item_t res;
    key_mask = (KEY_BITS >= KEY_W) ? '1 : ((KEY_W'(1) << KEY_BITS) - 1);
    first    = req.first_key & key_mask;
    second   = req.second_key & key_mask;
    res      = '0;
    // add and delete enter missing keys, first key before second
    if (req.opcode == brpt_pkg::OP_ADD || req.opcode == brpt_pkg::OP_DELETE) begin
      admit_key(first);
      admit_key(second);
    end
    row = locate_key(first);
    col = locate_key(second);
    if (row >= 0 && col >= 0) begin
      res.pair_present = 1'b1;
      if (req.opcode == brpt_pkg::OP_ADD) begin
        relation[row][col] = 1'b1;
      end else if (req.opcode == brpt_pkg::OP_DELETE) begin
        relation[row][col] = 1'b0;
      end
      res.related = relation[row][col];
    end
    res.element_count = key_total[brpt_pkg::COUNT_FIELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Results first, so a result cannot be matched with a request taken at the same edge
  always @(posedge clk) begin
    brpt_pkg::out_item_t want;
    if (!rst_n) begin
      key_total = 0;
      for (int i = 0; i < TABLE_SIZE; i++) relation[i] = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested result", 32'(out_data), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.related !== want.related)
            report_mismatch("related", 32'(out_data.related), 32'(want.related));
          if (out_data.pair_present !== want.pair_present)
            report_mismatch("pair_present", 32'(out_data.pair_present),
                            32'(want.pair_present));
          if (out_data.element_count !== want.element_count)
            report_mismatch("element_count", 32'(out_data.element_count),
                            32'(want.element_count));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_request(in_data));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* sim/testbench.sv */
// Stimulus, clock, reset and verdict for the binary relation pair table.
`timescale 1ns / 1ps

module testbench;

  localparam int OP_W  = brpt_pkg::OPCODE_W;
  localparam int KEY_W = brpt_pkg::KEY_FIELD_W;

  // Spare opcode, handled by the block as a query
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;
  localparam logic [OP_W-1:0] OP_ADD    = brpt_pkg::OP_ADD;
  localparam logic [OP_W-1:0] OP_DELETE = brpt_pkg::OP_DELETE;
  localparam logic [OP_W-1:0] OP_QUERY  = brpt_pkg::OP_QUERY;
  localparam int POOL_SIZE = 96;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  brpt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  brpt_pkg::out_item_t out_data;
  int                  fail_count;
  int                  outstanding;

  int  sender_idle_pct   = 0;
  int  receiver_stall_pct = 0;
  bit  long_hold          = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  binary_relation_pair_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  relation_table_monitor scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic brpt_pkg::in_item_t pack_request(input logic [OP_W-1:0] op,
                                                      input logic [KEY_W-1:0] first,
                                                      input logic [KEY_W-1:0] second);
    brpt_pkg::in_item_t req;
    req.opcode     = op;
    req.first_key  = first;
    req.second_key = second;
    return req;
  endfunction

  // Entered and left at a falling edge; valid stays up across back-to-back requests
  task automatic send_request(input brpt_pkg::in_item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly keys from the first span entries of the pool, now and then a fresh one
  function automatic logic [KEY_W-1:0] pick_key(input int span);
    if ($urandom_range(99) < 4) return $urandom;
    return key_pool[$urandom_range(span - 1)];
  endfunction

  task automatic send_random(input int count, input int span);
    int               roll;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] first;
    logic [KEY_W-1:0] second;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35)      op = OP_ADD;
      else if (roll < 55) op = OP_DELETE;
      else if (roll < 95) op = OP_QUERY;
      else                op = OP_SPARE;
      first  = pick_key(span);
      second = ($urandom_range(99) < 5) ? first : pick_key(span);
      send_request(pack_request(op, first, second));
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: absent keys, diagonal pairs, extreme keys, spare opcode
    send_request(pack_request(OP_QUERY,  32'h0000_0000, 32'h0000_0000));
    send_request(pack_request(OP_ADD,    32'h0000_0000, 32'h0000_0000));
    send_request(pack_request(OP_QUERY,  32'h0000_0000, 32'h0000_0000));
    send_request(pack_request(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000));
    send_request(pack_request(OP_QUERY,  32'hFFFF_FFFF, 32'h0000_0000));
    send_request(pack_request(OP_QUERY,  32'h0000_0000, 32'hFFFF_FFFF));
    send_request(pack_request(OP_SPARE,  32'hFFFF_FFFF, 32'h0000_0000));
    send_request(pack_request(OP_SPARE,  32'h0000_0001, 32'h0000_0002));
    send_request(pack_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
    send_request(pack_request(OP_QUERY,  32'hFFFF_FFFF, 32'h0000_0000));
    send_request(pack_request(OP_DELETE, 32'hAAAA_AAAA, 32'h5555_5555));
    send_request(pack_request(OP_QUERY,  32'hAAAA_AAAA, 32'h5555_5555));
    send_request(pack_request(OP_ADD,    32'h5555_5555, 32'hAAAA_AAAA));
    send_request(pack_request(OP_ADD,    32'h5555_5555, 32'hAAAA_AAAA));
    send_request(pack_request(OP_QUERY,  32'h5555_5555, 32'hAAAA_AAAA));
    send_request(pack_request(OP_QUERY,  32'h1234_5678, 32'h0000_0000));
    send_request(pack_request(OP_ADD,    32'h8000_0000, 32'h8000_0000));
    send_request(pack_request(OP_QUERY,  32'h8000_0000, 32'h8000_0000));
    send_request(pack_request(OP_DELETE, 32'h8000_0000, 32'h8000_0000));
    send_request(pack_request(OP_QUERY,  32'h8000_0000, 32'h8000_0000));

    // Random phases; the key span grows so the table fills up at the end
    send_random(200, 24);
    sender_idle_pct = 49;
    send_random(200, 32);
    sender_idle_pct    = 0;
    receiver_stall_pct = 49;
    send_random(200, 40);

    // Receiver holds off while requests keep coming
    receiver_stall_pct = 0;
    long_hold          = 1'b1;
    send_random(40, 40);

    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    send_random(220, POOL_SIZE);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
